### rtl/core/fbd_pkg.sv
// Shared types, byte table and key schedule for the 64-bit Feistel decryptor.
package fbd_pkg;

  localparam int RoundCount = 16;

  typedef logic [7:0]        byte_t;
  typedef logic [15:0]       word_t;
  typedef logic [11:0][7:0]  subkey_t;

  // Four working words; r0 is the most significant word of the block.
  typedef struct packed {
    word_t r0;
    word_t r1;
    word_t r2;
    word_t r3;
  } state_t;

  // Half-way point of a round: the words plus the first two G bytes of each G.
  typedef struct packed {
    state_t st;
    byte_t  a_g3;
    byte_t  a_g4;
    byte_t  b_g3;
    byte_t  b_g4;
  } mid_t;

  localparam byte_t SBOX [0:255] = '{
    8'ha3,8'hd7,8'h09,8'h83,8'hf8,8'h48,8'hf6,8'hf4,8'hb3,8'h21,8'h15,8'h78,8'h99,8'hb1,8'haf,8'hf9,
    8'he7,8'h2d,8'h4d,8'h8a,8'hce,8'h4c,8'hca,8'h2e,8'h52,8'h95,8'hd9,8'h1e,8'h4e,8'h38,8'h44,8'h28,
    8'h0a,8'hdf,8'h02,8'ha0,8'h17,8'hf1,8'h60,8'h68,8'h12,8'hb7,8'h7a,8'hc3,8'he9,8'hfa,8'h3d,8'h53,
    8'h96,8'h84,8'h6b,8'hba,8'hf2,8'h63,8'h9a,8'h19,8'h7c,8'hae,8'he5,8'hf5,8'hf7,8'h16,8'h6a,8'ha2,
    8'h39,8'hb6,8'h7b,8'h0f,8'hc1,8'h93,8'h81,8'h1b,8'hee,8'hb4,8'h1a,8'hea,8'hd0,8'h91,8'h2f,8'hb8,
    8'h55,8'hb9,8'hda,8'h85,8'h3f,8'h41,8'hbf,8'he0,8'h5a,8'h58,8'h80,8'h5f,8'h66,8'h0b,8'hd8,8'h90,
    8'h35,8'hd5,8'hc0,8'ha7,8'h33,8'h06,8'h65,8'h69,8'h45,8'h00,8'h94,8'h56,8'h6d,8'h98,8'h9b,8'h76,
    8'h97,8'hfc,8'hb2,8'hc2,8'hb0,8'hfe,8'hdb,8'h20,8'he1,8'heb,8'hd6,8'he4,8'hdd,8'h47,8'h4a,8'h1d,
    8'h42,8'hed,8'h9e,8'h6e,8'h49,8'h3c,8'hcd,8'h43,8'h27,8'hd2,8'h07,8'hd4,8'hde,8'hc7,8'h67,8'h18,
    8'h89,8'hcb,8'h30,8'h1f,8'h8d,8'hc6,8'h8f,8'haa,8'hc8,8'h74,8'hdc,8'hc9,8'h5d,8'h5c,8'h31,8'ha4,
    8'h70,8'h88,8'h61,8'h2c,8'h9f,8'h0d,8'h2b,8'h87,8'h50,8'h82,8'h54,8'h64,8'h26,8'h7d,8'h03,8'h40,
    8'h34,8'h4b,8'h1c,8'h73,8'hd1,8'hc4,8'hfd,8'h3b,8'hcc,8'hfb,8'h7f,8'hab,8'he6,8'h3e,8'h5b,8'ha5,
    8'had,8'h04,8'h23,8'h9c,8'h14,8'h51,8'h22,8'hf0,8'h29,8'h79,8'h71,8'h7e,8'hff,8'h8c,8'h0e,8'he2,
    8'h0c,8'hef,8'hbc,8'h72,8'h75,8'h6f,8'h37,8'ha1,8'hec,8'hd3,8'h8e,8'h62,8'h8b,8'h86,8'h10,8'he8,
    8'h08,8'h77,8'h11,8'hbe,8'h92,8'h4f,8'h24,8'hc5,8'h32,8'h36,8'h9d,8'hcf,8'hf3,8'ha6,8'hbb,8'hac,
    8'h5e,8'h6c,8'ha9,8'h13,8'h57,8'h25,8'hb5,8'he3,8'hbd,8'ha8,8'h3a,8'h01,8'h05,8'h59,8'h2a,8'h46
  };

  // Draw i of round rnd: key rotated right by (12*rnd + i) mod 64, then
  // byte (4*rnd + i mod 4) mod 8 with byte 0 at the top. Pure wiring for
  // constant rnd and i.
  function automatic byte_t subkey_byte(input logic [63:0] key, input int rnd, input int i);
    logic [63:0] rk;
    int          s;
    int          b;
    s  = (12 * rnd + i) % 64;
    rk = (key >> s) | (key << ((64 - s) % 64));
    b  = (4 * rnd + (i % 4)) % 8;
    return rk[8 * (7 - b) +: 8];
  endfunction

  function automatic subkey_t round_keys(input logic [63:0] key, input int rnd);
    subkey_t sk;
    for (int i = 0; i < 12; i++) begin
      sk[i] = subkey_byte(key, rnd, i);
    end
    return sk;
  endfunction

endpackage

### rtl/core/fbd_round.sv
// One Feistel round, split into two register stages (G front half, G back half + mix).
module fbd_round (
  input  logic             clk,
  input  logic             rst_n,
  input  fbd_pkg::subkey_t sk,
  input  logic             in_valid,
  output logic             in_ready,
  input  fbd_pkg::state_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output fbd_pkg::state_t  out_data
);

  logic            a_v_r;
  fbd_pkg::mid_t   a_r;
  fbd_pkg::mid_t   a_nxt;
  logic            a_ready;
  logic            b_v_r;
  fbd_pkg::state_t b_r;
  fbd_pkg::state_t b_nxt;
  logic            b_ready;

  fbd_pkg::byte_t  a_g5, a_g6, b_g5, b_g6;
  fbd_pkg::word_t  t0, t1, f0, f1, m3;

  assign b_ready  = !b_v_r || out_ready;
  assign a_ready  = !a_v_r || b_ready;
  assign in_ready = a_ready;

  // First two table steps of both G permutations.
  always_comb begin
    a_nxt.st   = in_data;
    a_nxt.a_g3 = fbd_pkg::SBOX[in_data.r0[7:0] ^ sk[11]] ^ in_data.r0[15:8];
    a_nxt.a_g4 = fbd_pkg::SBOX[a_nxt.a_g3 ^ sk[10]] ^ in_data.r0[7:0];
    a_nxt.b_g3 = fbd_pkg::SBOX[in_data.r1[7:0] ^ sk[7]] ^ in_data.r1[15:8];
    a_nxt.b_g4 = fbd_pkg::SBOX[a_nxt.b_g3 ^ sk[6]] ^ in_data.r1[7:0];
  end

  // Last two table steps, the F sums and the word mix.
  always_comb begin
    a_g5 = fbd_pkg::SBOX[a_r.a_g4 ^ sk[9]] ^ a_r.a_g3;
    a_g6 = fbd_pkg::SBOX[a_g5 ^ sk[8]] ^ a_r.a_g4;
    b_g5 = fbd_pkg::SBOX[a_r.b_g4 ^ sk[5]] ^ a_r.b_g3;
    b_g6 = fbd_pkg::SBOX[b_g5 ^ sk[4]] ^ a_r.b_g4;
    t0   = {a_g5, a_g6};
    t1   = {b_g5, b_g6};
    f0   = t0 + {t1[14:0], 1'b0} + {sk[3], sk[2]};
    f1   = {t0[14:0], 1'b0} + t1 + {sk[1], sk[0]};
    m3   = a_r.st.r3 ^ f1;
    b_nxt.r0 = {a_r.st.r2[14:0], a_r.st.r2[15]} ^ f0;
    b_nxt.r1 = {m3[0], m3[15:1]};
    b_nxt.r2 = a_r.st.r0;
    b_nxt.r3 = a_r.st.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (a_ready) a_v_r <= in_valid;
      if (b_ready) b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) a_r <= a_nxt;
    if (b_ready && a_v_r)    b_r <= b_nxt;
  end

  assign out_valid = b_v_r;
  assign out_data  = b_r;

endmodule

### rtl/core/feistel64_block_decrypt.sv
// Top level: key register, input whitening, 16 pipelined rounds, output whitening.
//
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  input    | in_valid, in_ready, in_cipher_block     | in
//  result   | out_valid, out_ready, out_plain_block   | out
//  config   | cfg_write_en, cfg_cipher_key            | in
//
// One block per cycle sustained while out_ready holds; the pipe is a whitening stage,
// two stages per round for 16 rounds and an output register. Each round's depth
// is set by the chain of four byte-table lookups in G, cut two and two.
// Reset (rst_n, synchronous) clears all valid bits and the key to zero.
// Stalls: every stage takes a new transfer when it is empty or its
// successor moves, so bubbles close up and nothing is dropped or repeated.
// The user changes the key only while the pipe is empty, which the block does not enforce; all rounds read it directly.
module feistel64_block_decrypt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [63:0] cfg_cipher_key,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_cipher_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_plain_block
);

  logic [63:0]      key_r;

  // Whitening stage
  logic             w_v_r;
  fbd_pkg::state_t  w_r;
  logic             w_ready;
  logic [63:0]      w_nxt;

  // Round chain: index k is the input of round k, index 16 the last output.
  logic             rv    [fbd_pkg::RoundCount + 1];
  logic             rr    [fbd_pkg::RoundCount + 1];
  fbd_pkg::state_t  rd    [fbd_pkg::RoundCount + 1];
  fbd_pkg::subkey_t rk    [fbd_pkg::RoundCount];

  // Output register
  logic             o_v_r;
  logic [63:0]      o_r;
  logic             o_ready;
  fbd_pkg::state_t  fin;

  always_ff @(posedge clk) begin
    if (!rst_n) key_r <= '0;
    else if (cfg_write_en) key_r <= cfg_cipher_key;
  end

  // Input whitening
  assign w_nxt    = in_cipher_block ^ key_r;
  assign w_ready  = !w_v_r || rr[0];
  assign in_ready = w_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) w_v_r <= 1'b0;
    else if (w_ready) w_v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (w_ready && in_valid) w_r <= w_nxt;
  end

  assign rv[0] = w_v_r;
  assign rd[0] = w_r;

  for (genvar g = 0; g < fbd_pkg::RoundCount; g++) begin : g_round
    // Subkeys are fixed wiring of the key for each round.
    assign rk[g] = fbd_pkg::round_keys(key_r, g);

    fbd_round u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .sk        (rk[g]),
      .in_valid  (rv[g]),
      .in_ready  (rr[g]),
      .in_data   (rd[g]),
      .out_valid (rv[g + 1]),
      .out_ready (rr[g + 1]),
      .out_data  (rd[g + 1])
    );
  end

  // Final swap back (R2:R3:R0:R1) and output whitening.
  assign fin     = rd[fbd_pkg::RoundCount];
  assign o_ready = !o_v_r || out_ready;
  assign rr[fbd_pkg::RoundCount] = o_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) o_v_r <= 1'b0;
    else if (o_ready) o_v_r <= rv[fbd_pkg::RoundCount];
  end

  always_ff @(posedge clk) begin
    if (o_ready && rv[fbd_pkg::RoundCount]) o_r <= {fin.r2, fin.r3, fin.r0, fin.r1} ^ key_r;
  end

  assign out_valid       = o_v_r;
  assign out_plain_block = o_r;

endmodule
